// ===== design/asat_pkg.sv =====
// ----------------------------------------------------------------------------
// asat_pkg: shared types, constants and curve tables
// Fixed-point constants for the Q4.20 datapath, the per-drive coefficient
// bundle, and the tanh and exp lookup tables with their fetch helper.
// ----------------------------------------------------------------------------
package asat_pkg;

  localparam int SampleBits   = 24;
  localparam int FracBits     = 20;
  localparam int TabEntries   = 256;
  localparam int TabIdxBits   = $clog2(TabEntries);
  // Table arguments span [0,16), which is FracBits + 4 bits of magnitude.
  localparam int TabFracBits  = FracBits + 4 - TabIdxBits;

  localparam int ONE          = 1 << FracBits;
  localparam int TENTH        = 104858;
  localparam int LIM          = 996147;
  localparam int KNEE         = 52429;
  localparam int EMPH_K       = 314573;
  localparam int WET_BASE     = 419430;
  localparam int WET_K        = 629146;
  localparam int PREGAIN_K    = 12288;
  localparam int DRIVE_K      = 24576;
  localparam int DRIVE_FULL   = 256;
  localparam int TWO_STAGE_MIN = 180;
  localparam int LUT_END      = 16 << FracBits;

  localparam logic signed [23:0] SLOPE_POS = 24'sd1258291;
  localparam logic signed [23:0] SLOPE_NEG = 24'sd838861;

  localparam longint ONE30  = 64'sd1 <<< 30;
  localparam longint E1_Q30 = 64'sd395007542;

  typedef struct packed {
    logic signed [23:0] pregain;
    logic signed [23:0] drive;
    logic signed [23:0] emph;
    logic signed [23:0] wet;
    logic signed [23:0] omw;
  } coef_t;

  typedef struct packed {
    logic        [20:0] base;
    logic signed [21:0] diff;
    logic        [TabFracBits-1:0] frac;
  } lut_t;

  typedef logic [20:0] lut_tab_t [0:TabEntries];

  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] x,
                                                input int unsigned sh);
    return (x + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [23:0] clamp24(input logic signed [63:0] x);
    logic signed [23:0] r;
    if (x > 64'sd8388607) r = 24'sh7fffff;
    else if (x < -64'sd8388608) r = 24'sh800000;
    else r = 24'(x);
    return r;
  endfunction

  // Long division used only while the tables are built; both operands are
  // nonnegative and the quotient is truncated.
  function automatic longint udiv(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & 64'sd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'sd1 <<< b);
      end
    end
    return q;
  endfunction

  // exp(-num/TabEntries) in Q2.30, series on the remainder, then whole steps.
  function automatic longint expneg_q30(input longint num);
    longint n;
    longint r;
    longint term;
    longint sum;
    n = num / TabEntries;
    r = num % TabEntries;
    term = ONE30;
    sum = ONE30;
    for (int k = 1; k < 40; k++) begin
      if (term != 0) begin
        term = udiv(term * r, longint'(TabEntries) * k);
        sum = (k % 2 == 1) ? sum - term : sum + term;
      end
    end
    for (longint j = 0; j < n; j++) begin
      if (sum != 0) sum = (sum * E1_Q30 + (ONE30 >>> 1)) >>> 30;
    end
    return sum;
  endfunction

  function automatic lut_tab_t build_tab(input logic want_exp);
    lut_tab_t t;
    longint e;
    longint e2;
    for (int i = 0; i <= TabEntries; i++) begin
      e = expneg_q30(longint'(16 * i));
      e2 = expneg_q30(longint'(32 * i));
      if (want_exp) t[i] = 21'((e + 512) >>> 10);
      else t[i] = 21'(udiv(((ONE30 - e2) <<< FracBits) + ((ONE30 + e2) >>> 1),
                           ONE30 + e2));
    end
    return t;
  endfunction

  localparam lut_tab_t TANH_TAB = build_tab(1'b0);
  localparam lut_tab_t EXP_TAB  = build_tab(1'b1);

  // First half of an interpolated lookup: segment base, slope and fraction.
  function automatic lut_t lut_fetch(input lut_tab_t tab, input logic signed [31:0] x);
    lut_t r;
    logic [TabIdxBits-1:0] idx;
    logic [TabIdxBits:0]   nxt;
    idx = x[TabIdxBits+TabFracBits-1:TabFracBits];
    nxt = {1'b0, idx} + 1'b1;
    r.base = tab[0];
    r.diff = '0;
    r.frac = '0;
    if (x >= LUT_END) begin
      r.base = tab[TabEntries];
    end else if (x > 0) begin
      r.base = tab[idx];
      r.diff = $signed({1'b0, tab[nxt]}) - $signed({1'b0, tab[idx]});
      r.frac = x[TabFracBits-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/asat_stage.sv =====
// ----------------------------------------------------------------------------
// asat_stage: one waveshaping pass
// Pre-gain, asymmetric tanh shaping with emphasis, soft knee and dry/wet mix,
// cut into sixteen register stages. A pass word leaves the input unchanged.
// ----------------------------------------------------------------------------
module asat_stage import asat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               pass_i,
  input  logic signed [23:0] sample_i,
  input  coef_t              coef_i,
  output logic               valid_o,
  output logic signed [23:0] sample_o
);

  logic               v_q    [1:16];
  logic signed [23:0] s_q    [1:15];
  logic               pass_q [1:15];
  logic               pos_q  [2:13];
  logic               agt_q  [3:9];

  logic signed [47:0] p1_q, p1_d;
  logic signed [24:0] a2_q, a2_d;
  logic               pos2_d;
  logic signed [23:0] sh2;
  logic signed [48:0] t1_3_q, t1_3_d;
  lut_t               ex3_q, ex3_d;
  logic               agt3_d;
  logic signed [27:0] t2;
  logic signed [51:0] prod4_q, prod4_d;
  logic signed [38:0] exi4_q, exi4_d;
  logic        [20:0] eb4_q;
  logic signed [31:0] arg5;
  lut_t               tl5_q, tl5_d;
  logic signed [22:0] e5_q, e5_d, e6_q, e7_q;
  logic signed [38:0] ti6_q, ti6_d;
  logic        [20:0] tb6_q;
  logic signed [22:0] m7_q, m7_d, m8_q, m9_q;
  logic signed [46:0] em8_q, em8_d;
  logic signed [22:0] ome8_q, ome8_d;
  logic signed [45:0] ep9_q, ep9_d;
  logic signed [22:0] m10_q, m10_d, m11_q, m12_q, m13_q;
  logic               big11_q, big11_d, big12_q, big13_q;
  lut_t               la11_q, la11_d;
  logic signed [38:0] li12_q, li12_d;
  logic        [20:0] lb12_q;
  logic signed [22:0] lk13;
  logic signed [46:0] kp13_q, kp13_d;
  logic signed [23:0] mm, m14_q, m14_d;
  logic signed [47:0] dry15_q, dry15_d, wet15_q, wet15_d;
  logic signed [23:0] y16_q, y16_d;

  always_comb begin
    p1_d    = sample_i * coef_i.pregain;
    sh2     = clamp24(rnd_sh(64'(p1_q), FracBits));
    pos2_d  = sh2 > 0;
    a2_d    = pos2_d ? 25'(sh2) : -25'(sh2);
    t1_3_d  = a2_q * coef_i.drive;
    ex3_d   = lut_fetch(EXP_TAB, 32'(a2_q) * 32'sd5);
    agt3_d  = pos_q[2] && (a2_q > TENTH);
    t2      = 28'(rnd_sh(64'(t1_3_q), FracBits));
    prod4_d = t2 * (pos_q[3] ? SLOPE_POS : SLOPE_NEG);
    exi4_d  = ex3_q.diff * $signed({1'b0, ex3_q.frac});
    arg5    = 32'(rnd_sh(64'(prod4_q), FracBits));
    tl5_d   = lut_fetch(TANH_TAB, arg5);
    e5_d    = $signed({2'b0, eb4_q}) + 23'(rnd_sh(64'(exi4_q), TabFracBits));
    ti6_d   = tl5_q.diff * $signed({1'b0, tl5_q.frac});
    m7_d    = $signed({2'b0, tb6_q}) + 23'(rnd_sh(64'(ti6_q), TabFracBits));
    em8_d   = coef_i.emph * m7_q;
    ome8_d  = 23'(ONE) - e7_q;
    ep9_d   = 23'(rnd_sh(64'(em8_q), FracBits)) * ome8_q;
    // The emphasis term only applies to positive words above one tenth.
    m10_d   = agt_q[9] ? m9_q + 23'(rnd_sh(64'(ep9_q), FracBits)) : m9_q;
    big11_d = m10_q > LIM;
    la11_d  = lut_fetch(TANH_TAB, (32'(m10_q) - 32'(LIM)) * 32'sd10);
    li12_d  = la11_q.diff * $signed({1'b0, la11_q.frac});
    lk13    = $signed({2'b0, lb12_q}) + 23'(rnd_sh(64'(li12_q), TabFracBits));
    kp13_d  = 24'(KNEE) * lk13;
    mm      = big13_q ? 24'(64'(LIM) + rnd_sh(64'(kp13_q), FracBits)) : 24'(m13_q);
    m14_d   = pos_q[13] ? mm : -mm;
    dry15_d = s_q[14] * coef_i.omw;
    wet15_d = m14_q * coef_i.wet;
    y16_d   = pass_q[15] ? s_q[15]
            : clamp24(rnd_sh(64'(dry15_q), FracBits) + rnd_sh(64'(wet15_q), FracBits));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= 16; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[1] <= valid_i;
      for (int i = 2; i <= 16; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[1]    <= sample_i;
      pass_q[1] <= pass_i;
      for (int i = 2; i <= 15; i++) begin
        s_q[i]    <= s_q[i-1];
        pass_q[i] <= pass_q[i-1];
      end
      pos_q[2] <= pos2_d;
      for (int i = 3; i <= 13; i++) pos_q[i] <= pos_q[i-1];
      agt_q[3] <= agt3_d;
      for (int i = 4; i <= 9; i++) agt_q[i] <= agt_q[i-1];
      p1_q    <= p1_d;
      a2_q    <= a2_d;
      t1_3_q  <= t1_3_d;
      ex3_q   <= ex3_d;
      prod4_q <= prod4_d;
      exi4_q  <= exi4_d;
      eb4_q   <= ex3_q.base;
      tl5_q   <= tl5_d;
      e5_q    <= e5_d;
      ti6_q   <= ti6_d;
      tb6_q   <= tl5_q.base;
      e6_q    <= e5_q;
      m7_q    <= m7_d;
      e7_q    <= e6_q;
      em8_q   <= em8_d;
      m8_q    <= m7_q;
      ome8_q  <= ome8_d;
      ep9_q   <= ep9_d;
      m9_q    <= m8_q;
      m10_q   <= m10_d;
      big11_q <= big11_d;
      la11_q  <= la11_d;
      m11_q   <= m10_q;
      li12_q  <= li12_d;
      lb12_q  <= la11_q.base;
      big12_q <= big11_q;
      m12_q   <= m11_q;
      kp13_q  <= kp13_d;
      big13_q <= big12_q;
      m13_q   <= m12_q;
      m14_q   <= m14_d;
      dry15_q <= dry15_d;
      wet15_q <= wet15_d;
      y16_q   <= y16_d;
    end
  end

  assign valid_o  = v_q[16];
  assign sample_o = y16_q;

endmodule

// ===== design/asymmetric_tanh_saturator.sv =====
// An accepted input word passes through two 16-stage shaping passes and then
// through the output register before it reaches the output.
// Throughput: one word per cycle unless stalled, set by the fully pipelined passes.
// A skid register at the output absorbs one word while the output is stalled.
// Reset clears all valid bits, the skid and the drive register (drive 0).
// ----------------------------------------------------------------------------
// asymmetric_tanh_saturator: top level
// Converts Q1.23 words to Q4.20, runs two shaping passes (the second one is
// bypassed at low drive), converts back with saturation and buffers the result.
// ----------------------------------------------------------------------------
module asymmetric_tanh_saturator import asat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [8:0]         drive_level_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [23:0] sample_in_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [23:0] sample_out_o
);

  logic [8:0]         drive_q;
  logic [8:0]         d;
  int                 di;
  coef_t              coef;
  logic               two_stage;
  logic               en;
  logic signed [24:0] sx;
  logic signed [23:0] s_in;
  logic               v1, v2;
  logic signed [23:0] y1, y2;
  logic signed [23:0] fin;
  logic               out_v_q, skid_v_q;
  logic signed [23:0] out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= '0;
    end else if (cfg_we_i) begin
      drive_q <= drive_level_i;
    end
  end

  always_comb begin
    d            = (drive_q > 9'(DRIVE_FULL)) ? 9'(DRIVE_FULL) : drive_q;
    di           = int'(d);
    coef.pregain = 24'(ONE + PREGAIN_K * di);
    coef.drive   = 24'(ONE + DRIVE_K * di);
    coef.emph    = 24'((EMPH_K * di + 128) >>> 8);
    coef.wet     = 24'(WET_BASE + ((WET_K * di + 128) >>> 8));
    coef.omw     = 24'(ONE) - coef.wet;
    two_stage    = d >= 9'(TWO_STAGE_MIN);
  end

  assign en      = !skid_v_q;
  assign stall_o = skid_v_q;

  assign sx   = 25'(sample_in_i) + 25'sd4;
  assign s_in = 24'(sx >>> (SampleBits - 1 - FracBits));

  asat_stage u_stage1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i), .pass_i(1'b0),
    .sample_i(s_in), .coef_i(coef), .valid_o(v1), .sample_o(y1)
  );

  asat_stage u_stage2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .pass_i(!two_stage),
    .sample_i(y1), .coef_i(coef), .valid_o(v2), .sample_o(y2)
  );

  assign fin = clamp24(64'(y2) <<< (SampleBits - 1 - FracBits));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !stall_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= v2;
      end
    end else if (v2 && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !stall_i) begin
      out_q <= skid_v_q ? skid_q : fin;
    end else if (v2 && en) begin
      skid_q <= fin;
    end
  end

  assign valid_o      = out_v_q;
  assign sample_out_o = out_q;

endmodule

// ===== design/asat_checker.sv =====
// ----------------------------------------------------------------------------
// asat_checker: port-level checks
// Watches the handshakes of the top level and the output buffering.
// ----------------------------------------------------------------------------
module asat_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [8:0]         drive_level_i,
  input logic               valid_i,
  input logic               stall_o,
  input logic signed [23:0] sample_in_i,
  input logic               valid_o,
  input logic               stall_i,
  input logic signed [23:0] sample_out_o
);

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(sample_out_o))
    else $error("output word changed while stalled");

  // The input only stalls while a finished word is waiting.
  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("input stalled without a waiting output word");

  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_o && stall_i))
    else $error("input stall raised without an output stall");

  // Once the output word is taken, the input is free again.
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i |=> !stall_o)
    else $error("input still stalled after output drained");

endmodule

bind asymmetric_tanh_saturator asat_checker u_asat_checker (.*);
